@@ sv/tpc_pkg.sv @@
// Shared types, codes and reset values of the traffic phase controller.
`default_nettype none

package tpc_pkg;

    typedef enum logic [3:0] {
        PH_NS_G = 4'd0,
        PH_NS_Y = 4'd1,
        PH_AR_1 = 4'd2,
        PH_EW_G = 4'd3,
        PH_EW_Y = 4'd4,
        PH_AR_2 = 4'd5,
        PH_WALK = 4'd6,
        PH_EM_G = 4'd7,
        PH_EM_Y = 4'd8,
        PH_HALT = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        PT_NONE  = 2'd0,
        PT_PED   = 2'd1,
        PT_EMERG = 2'd2
    } preempt_t;

    typedef enum logic [1:0] {
        LAMP_RED    = 2'd0,
        LAMP_YELLOW = 2'd1,
        LAMP_GREEN  = 2'd2
    } lamp_t;

    typedef enum logic [2:0] {
        REG_GREEN_BASE  = 3'd0,
        REG_GREEN_PER_V = 3'd1,
        REG_GREEN_MIN   = 3'd2,
        REG_GREEN_MAX   = 3'd3,
        REG_YELLOW      = 3'd4,
        REG_ALL_RED     = 3'd5,
        REG_WALK        = 3'd6,
        REG_EMERGENCY   = 3'd7
    } cfg_addr_t;

    typedef struct packed {
        logic [7:0] green_base;
        logic [3:0] green_per_vehicle;
        logic [7:0] green_min;
        logic [7:0] green_max;
        logic [7:0] yellow_time;
        logic [7:0] all_red_time;
        logic [7:0] walk_time;
        logic [7:0] emergency_time;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        green_base:        8'd10,
        green_per_vehicle: 4'd2,
        green_min:         8'd5,
        green_max:         8'd60,
        yellow_time:       8'd3,
        all_red_time:      8'd2,
        walk_time:         8'd10,
        emergency_time:    8'd10
    };

    typedef struct packed {
        phase_t     phase;
        logic [7:0] timer;
        logic       ped_latched;
        logic       emerg_latched;
        logic [1:0] emerg_dir;
        logic       return_to_ns;
        preempt_t   preempt;
        logic       walk_flag;
        logic       emerg_flag;
        logic [1:0] served_dir;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:         PH_NS_G,
        timer:         8'd0,
        ped_latched:   1'b0,
        emerg_latched: 1'b0,
        emerg_dir:     2'd0,
        return_to_ns:  1'b0,
        preempt:       PT_NONE,
        walk_flag:     1'b0,
        emerg_flag:    1'b0,
        served_dir:    2'd0
    };

    // A zero duration still lasts one second.
    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    // Base time plus queued vehicles times per-vehicle time, clamped low then high.
    function automatic logic [7:0] green_len(input cfg_t cfg, input logic [7:0] a,
                                             input logic [7:0] b);
        logic [8:0]  sum;
        logic [13:0] t;
        sum = {1'b0, a} + {1'b0, b};
        t = {6'd0, cfg.green_base} + ({5'd0, sum} * {10'd0, cfg.green_per_vehicle});
        if (t < {6'd0, cfg.green_min}) begin
            t = {6'd0, cfg.green_min};
        end
        if (t > {6'd0, cfg.green_max}) begin
            t = {6'd0, cfg.green_max};
        end
        return at_least_one(t[7:0]);
    endfunction

endpackage

`default_nettype wire

@@ sv/traffic_phase_controller_unit.sv @@
// Top level of the traffic phase controller: tick sequencer and result register.
`default_nettype none

// Four-way intersection phase sequencer, advanced by one tick beat per second.
// Input channel (s_*): each beat carries the pedestrian, emergency and stop
// requests plus the queue counts of the four approaches. Result channel (m_*):
// each accepted tick produces exactly one result beat with the four lamp
// colors, the phase code, the seconds left in the phase and status flags.
// Configuration channel (cfg_*): eight timing registers written by index; it is
// always ready and must only be written while no tick is in flight.
// Latency: the result of a tick is valid in the cycle after its acceptance.
// Throughput: one tick per clock cycle while the receiver keeps m_ready high, set by
// the combinational next-state logic between the phase state and the result register.
// Reset (aresetn low, synchronous): the timing registers return to defaults,
// the controller sits in NS green with its timer cleared so the first tick
// loads the green length, and the result register is emptied.
// Stalls: while the receiver holds m_ready low the result beat waits in the
// result register; s_ready drops until that beat is taken, so no tick is lost.
// A stop request halts the controller with all lamps red until the next reset.
module traffic_phase_controller_unit (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    // tick input channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_ped_request,
    input  wire logic       s_emerg_request,
    input  wire logic [1:0] s_emerg_direction,
    input  wire logic [7:0] s_count_north,
    input  wire logic [7:0] s_count_south,
    input  wire logic [7:0] s_count_east,
    input  wire logic [7:0] s_count_west,
    input  wire logic       s_stop_request,
    // result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [1:0]      m_lamp_north,
    output logic [1:0]      m_lamp_south,
    output logic [1:0]      m_lamp_east,
    output logic [1:0]      m_lamp_west,
    output logic [3:0]      m_phase_code,
    output logic [7:0]      m_seconds_left,
    output logic            m_walk_active,
    output logic            m_emergency_active,
    output logic            m_ped_pending
);

    tpc_pkg::cfg_t   cfg_reg;
    tpc_pkg::state_t state_reg;
    tpc_pkg::state_t state_next;

    logic            m_valid_reg;
    logic [1:0]      lamp_reg [4];
    logic [1:0]      lamp_next [4];
    logic [3:0]      phase_code_reg;
    logic [7:0]      seconds_left_reg;
    logic            walk_active_reg;
    logic            emergency_active_reg;
    logic            ped_pending_reg;

    logic            tick_accept;

    // The result register can take a new beat when empty or when its beat
    // leaves in this same cycle.
    assign s_ready     = !m_valid_reg || m_ready;
    assign tick_accept = s_valid && s_ready;
    assign cfg_ready   = 1'b1;

    // Loads a phase and its duration, with the side effects that entering
    // that phase has on latches and flags.
    function automatic tpc_pkg::state_t enter_phase(
        input tpc_pkg::state_t s, input tpc_pkg::phase_t p, input tpc_pkg::cfg_t cfg,
        input logic [7:0] cn, input logic [7:0] cs, input logic [7:0] ce,
        input logic [7:0] cw);
        tpc_pkg::state_t r;
        r = s;
        unique case (p)
            tpc_pkg::PH_NS_G, tpc_pkg::PH_EW_G: begin
                r.walk_flag    = 1'b0;
                r.emerg_flag   = 1'b0;
                r.return_to_ns = 1'b0;
                if (r.emerg_latched || r.ped_latched) begin
                    // A pending request skips the green entirely.
                    r.preempt = r.emerg_latched ? tpc_pkg::PT_EMERG : tpc_pkg::PT_PED;
                    r.phase   = (p == tpc_pkg::PH_NS_G) ? tpc_pkg::PH_NS_Y
                                                        : tpc_pkg::PH_EW_Y;
                    r.timer   = tpc_pkg::at_least_one(cfg.yellow_time);
                end else begin
                    r.phase = p;
                    r.timer = (p == tpc_pkg::PH_NS_G) ? tpc_pkg::green_len(cfg, cn, cs)
                                                      : tpc_pkg::green_len(cfg, ce, cw);
                end
            end
            tpc_pkg::PH_NS_Y, tpc_pkg::PH_EW_Y, tpc_pkg::PH_EM_Y: begin
                r.phase = p;
                r.timer = tpc_pkg::at_least_one(cfg.yellow_time);
            end
            tpc_pkg::PH_WALK: begin
                r.phase       = p;
                r.ped_latched = 1'b0;
                r.preempt     = tpc_pkg::PT_NONE;
                r.walk_flag   = 1'b1;
                r.emerg_flag  = 1'b0;
                r.timer       = tpc_pkg::at_least_one(cfg.walk_time);
            end
            tpc_pkg::PH_EM_G: begin
                r.phase         = p;
                r.emerg_latched = 1'b0;
                r.served_dir    = r.emerg_dir;
                r.preempt       = tpc_pkg::PT_NONE;
                r.emerg_flag    = 1'b1;
                r.walk_flag     = 1'b0;
                r.timer         = tpc_pkg::at_least_one(cfg.emergency_time);
            end
            default: begin
                r.phase = (p == tpc_pkg::PH_AR_2) ? tpc_pkg::PH_AR_2 : tpc_pkg::PH_AR_1;
                r.timer = tpc_pkg::at_least_one(cfg.all_red_time);
            end
        endcase
        return r;
    endfunction

    // Next state for one tick: stop check, request latching, then phase logic.
    always_comb begin
        tpc_pkg::state_t s;
        tpc_pkg::phase_t p;
        tpc_pkg::phase_t yel;
        s   = state_reg;
        p   = state_reg.phase;
        yel = (p == tpc_pkg::PH_NS_G) ? tpc_pkg::PH_NS_Y : tpc_pkg::PH_EW_Y;
        if (p == tpc_pkg::PH_HALT || s_stop_request) begin
            s.phase         = tpc_pkg::PH_HALT;
            s.timer         = 8'd0;
            s.ped_latched   = 1'b0;
            s.emerg_latched = 1'b0;
            s.return_to_ns  = 1'b0;
            s.preempt       = tpc_pkg::PT_NONE;
            s.walk_flag     = 1'b0;
            s.emerg_flag    = 1'b0;
        end else begin
            // Requests are only heard during a green, walk or emergency green.
            if (p == tpc_pkg::PH_NS_G || p == tpc_pkg::PH_EW_G ||
                p == tpc_pkg::PH_WALK || p == tpc_pkg::PH_EM_G) begin
                if (s_ped_request && !s.ped_latched && !s.emerg_latched) begin
                    s.ped_latched = 1'b1;
                end
                if (s_emerg_request) begin
                    s.emerg_latched = 1'b1;
                    s.emerg_dir     = s_emerg_direction;
                end
            end
            unique case (p)
                tpc_pkg::PH_NS_G, tpc_pkg::PH_EW_G: begin
                    // The first tick after reset finds the timer empty.
                    if (s.timer == 8'd0 && !s.ped_latched && !s.emerg_latched) begin
                        s = enter_phase(s, p, cfg_reg, s_count_north, s_count_south,
                                        s_count_east, s_count_west);
                    end
                    if (s.ped_latched || s.emerg_latched) begin
                        s.preempt = s.emerg_latched ? tpc_pkg::PT_EMERG : tpc_pkg::PT_PED;
                        s = enter_phase(s, yel, cfg_reg, s_count_north, s_count_south,
                                        s_count_east, s_count_west);
                    end else begin
                        s.timer = (s.timer != 8'd0) ? s.timer - 8'd1 : 8'd0;
                        if (s.timer == 8'd0) begin
                            s = enter_phase(s, yel, cfg_reg, s_count_north, s_count_south,
                                            s_count_east, s_count_west);
                        end
                    end
                end
                tpc_pkg::PH_NS_Y, tpc_pkg::PH_EW_Y: begin
                    s.timer = (s.timer != 8'd0) ? s.timer - 8'd1 : 8'd0;
                    if (s.timer == 8'd0) begin
                        s = enter_phase(s, (p == tpc_pkg::PH_NS_Y) ? tpc_pkg::PH_AR_1
                                                                   : tpc_pkg::PH_AR_2,
                                        cfg_reg, s_count_north, s_count_south,
                                        s_count_east, s_count_west);
                    end
                end
                tpc_pkg::PH_AR_1, tpc_pkg::PH_AR_2: begin
                    s.timer = (s.timer != 8'd0) ? s.timer - 8'd1 : 8'd0;
                    if (s.timer == 8'd0) begin
                        priority if (s.preempt == tpc_pkg::PT_EMERG) begin
                            s = enter_phase(s, tpc_pkg::PH_EM_G, cfg_reg, s_count_north,
                                            s_count_south, s_count_east, s_count_west);
                        end else if (s.preempt == tpc_pkg::PT_PED) begin
                            s = enter_phase(s, tpc_pkg::PH_WALK, cfg_reg, s_count_north,
                                            s_count_south, s_count_east, s_count_west);
                        end else if (s.return_to_ns || p == tpc_pkg::PH_AR_2) begin
                            s = enter_phase(s, tpc_pkg::PH_NS_G, cfg_reg, s_count_north,
                                            s_count_south, s_count_east, s_count_west);
                        end else begin
                            s = enter_phase(s, tpc_pkg::PH_EW_G, cfg_reg, s_count_north,
                                            s_count_south, s_count_east, s_count_west);
                        end
                    end
                end
                tpc_pkg::PH_WALK: begin
                    if (s.emerg_latched) begin
                        // All lamps are already red, so emergency green starts at once.
                        s = enter_phase(s, tpc_pkg::PH_EM_G, cfg_reg, s_count_north,
                                        s_count_south, s_count_east, s_count_west);
                    end else begin
                        s.timer = (s.timer != 8'd0) ? s.timer - 8'd1 : 8'd0;
                        if (s.timer == 8'd0) begin
                            s.return_to_ns = 1'b1;
                            s = enter_phase(s, tpc_pkg::PH_AR_1, cfg_reg, s_count_north,
                                            s_count_south, s_count_east, s_count_west);
                        end
                    end
                end
                tpc_pkg::PH_EM_G: begin
                    s.timer = (s.timer != 8'd0) ? s.timer - 8'd1 : 8'd0;
                    if (s.timer == 8'd0) begin
                        s = enter_phase(s, tpc_pkg::PH_EM_Y, cfg_reg, s_count_north,
                                        s_count_south, s_count_east, s_count_west);
                    end
                end
                tpc_pkg::PH_EM_Y: begin
                    s.timer = (s.timer != 8'd0) ? s.timer - 8'd1 : 8'd0;
                    if (s.timer == 8'd0) begin
                        s.return_to_ns = 1'b1;
                        s = enter_phase(s, tpc_pkg::PH_AR_1, cfg_reg, s_count_north,
                                        s_count_south, s_count_east, s_count_west);
                    end
                end
                default: begin
                    // A corrupted phase code recovers through an all-red.
                    s = enter_phase(s, tpc_pkg::PH_AR_1, cfg_reg, s_count_north,
                                    s_count_south, s_count_east, s_count_west);
                end
            endcase
        end
        state_next = s;
    end

    // Lamp colors follow from the phase that the tick leaves behind.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lamp_next[i] = tpc_pkg::LAMP_RED;
        end
        unique case (state_next.phase)
            tpc_pkg::PH_NS_G: begin
                lamp_next[0] = tpc_pkg::LAMP_GREEN;
                lamp_next[1] = tpc_pkg::LAMP_GREEN;
            end
            tpc_pkg::PH_NS_Y: begin
                lamp_next[0] = tpc_pkg::LAMP_YELLOW;
                lamp_next[1] = tpc_pkg::LAMP_YELLOW;
            end
            tpc_pkg::PH_EW_G: begin
                lamp_next[2] = tpc_pkg::LAMP_GREEN;
                lamp_next[3] = tpc_pkg::LAMP_GREEN;
            end
            tpc_pkg::PH_EW_Y: begin
                lamp_next[2] = tpc_pkg::LAMP_YELLOW;
                lamp_next[3] = tpc_pkg::LAMP_YELLOW;
            end
            tpc_pkg::PH_EM_G: begin
                lamp_next[state_next.served_dir] = tpc_pkg::LAMP_GREEN;
            end
            tpc_pkg::PH_EM_Y: begin
                lamp_next[state_next.served_dir] = tpc_pkg::LAMP_YELLOW;
            end
            default: begin
            end
        endcase
    end

    // Timing registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= tpc_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (tpc_pkg::cfg_addr_t'(cfg_index))
                tpc_pkg::REG_GREEN_BASE:  cfg_reg.green_base        <= cfg_data;
                tpc_pkg::REG_GREEN_PER_V: cfg_reg.green_per_vehicle <= cfg_data[3:0];
                tpc_pkg::REG_GREEN_MIN:   cfg_reg.green_min         <= cfg_data;
                tpc_pkg::REG_GREEN_MAX:   cfg_reg.green_max         <= cfg_data;
                tpc_pkg::REG_YELLOW:      cfg_reg.yellow_time       <= cfg_data;
                tpc_pkg::REG_ALL_RED:     cfg_reg.all_red_time      <= cfg_data;
                tpc_pkg::REG_WALK:        cfg_reg.walk_time         <= cfg_data;
                tpc_pkg::REG_EMERGENCY:   cfg_reg.emergency_time    <= cfg_data;
            endcase
        end
    end

    // Phase state and the result register; the payload is loaded with the
    // beat that it belongs to.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tpc_pkg::STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (tick_accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
                for (int i = 0; i < 4; i++) begin
                    lamp_reg[i] <= lamp_next[i];
                end
                phase_code_reg       <= state_next.phase;
                seconds_left_reg     <= state_next.timer;
                walk_active_reg      <= state_next.walk_flag;
                emergency_active_reg <= state_next.emerg_flag;
                ped_pending_reg      <= state_next.ped_latched;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_lamp_north       = lamp_reg[0];
    assign m_lamp_south       = lamp_reg[1];
    assign m_lamp_east        = lamp_reg[2];
    assign m_lamp_west        = lamp_reg[3];
    assign m_phase_code       = phase_code_reg;
    assign m_seconds_left     = seconds_left_reg;
    assign m_walk_active      = walk_active_reg;
    assign m_emergency_active = emergency_active_reg;
    assign m_ped_pending      = ped_pending_reg;

`ifndef SYNTHESIS
    // Once halted, the controller stays halted until reset.
    a_halt_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == tpc_pkg::PH_HALT |=> state_reg.phase == tpc_pkg::PH_HALT)
        else $error("controller left the halted phase");

    // Crossing directions are never released at the same time.
    a_no_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !((lamp_reg[0] != tpc_pkg::LAMP_RED ||
                           lamp_reg[1] != tpc_pkg::LAMP_RED) &&
                          (lamp_reg[2] != tpc_pkg::LAMP_RED ||
                           lamp_reg[3] != tpc_pkg::LAMP_RED)))
        else $error("conflicting approaches shown non-red together");

    // A tick that does not halt always leaves a loaded phase timer.
    a_timer_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_accept && !s_stop_request && state_reg.phase != tpc_pkg::PH_HALT
        |=> state_reg.timer != 8'd0)
        else $error("phase timer left empty after a tick");

    // Walk and emergency service never overlap.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(state_reg.walk_flag && state_reg.emerg_flag))
        else $error("walk and emergency flags both set");

    // The halted result shows every lamp red and no time left.
    a_halt_all_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && phase_code_reg == tpc_pkg::PH_HALT
        |-> lamp_reg[0] == tpc_pkg::LAMP_RED && lamp_reg[1] == tpc_pkg::LAMP_RED &&
            lamp_reg[2] == tpc_pkg::LAMP_RED && lamp_reg[3] == tpc_pkg::LAMP_RED &&
            seconds_left_reg == 8'd0)
        else $error("halted result is not all red");
`endif

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the traffic phase controller: directed and random tick traffic.
`timescale 1ns / 100ps

module tb_top;

    // The run is ended here if the controller stops answering.
    localparam int unsigned CYCLE_LIMIT = 400000;
    // The result of a tick appears in the cycle after acceptance, so a few spare
    // cycles after the last expected beat are enough to catch stray beats.
    localparam int TAIL_CYCLES = 4;
    localparam int MAX_PRINTED = 40;

    // One tick beat as the sender sees it.
    typedef struct packed {
        logic       ped;
        logic       emerg;
        logic [1:0] dir;
        logic [7:0] cn;
        logic [7:0] cs;
        logic [7:0] ce;
        logic [7:0] cw;
        logic       stop;
    } tick_t;

    // One result beat: lamp colors, phase, countdown and status flags.
    typedef struct packed {
        tpc_pkg::lamp_t  north;
        tpc_pkg::lamp_t  south;
        tpc_pkg::lamp_t  east;
        tpc_pkg::lamp_t  west;
        tpc_pkg::phase_t phase;
        logic [7:0]      secs;
        logic            walk;
        logic            emerg;
        logic            ped;
    } light_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;

    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = 3'd0;
    logic [7:0] cfg_data = 8'd0;

    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_ped_request = 1'b0;
    logic       s_emerg_request = 1'b0;
    logic [1:0] s_emerg_direction = 2'd0;
    logic [7:0] s_count_north = 8'd0;
    logic [7:0] s_count_south = 8'd0;
    logic [7:0] s_count_east = 8'd0;
    logic [7:0] s_count_west = 8'd0;
    logic       s_stop_request = 1'b0;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_lamp_north;
    logic [1:0] m_lamp_south;
    logic [1:0] m_lamp_east;
    logic [1:0] m_lamp_west;
    logic [3:0] m_phase_code;
    logic [7:0] m_seconds_left;
    logic       m_walk_active;
    logic       m_emergency_active;
    logic       m_ped_pending;

    traffic_phase_controller_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_ped_request     (s_ped_request),
        .s_emerg_request   (s_emerg_request),
        .s_emerg_direction (s_emerg_direction),
        .s_count_north     (s_count_north),
        .s_count_south     (s_count_south),
        .s_count_east      (s_count_east),
        .s_count_west      (s_count_west),
        .s_stop_request    (s_stop_request),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_lamp_north      (m_lamp_north),
        .m_lamp_south      (m_lamp_south),
        .m_lamp_east       (m_lamp_east),
        .m_lamp_west       (m_lamp_west),
        .m_phase_code      (m_phase_code),
        .m_seconds_left    (m_seconds_left),
        .m_walk_active     (m_walk_active),
        .m_emergency_active(m_emergency_active),
        .m_ped_pending     (m_ped_pending)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the controller: timing registers and sequencer state.
    // ------------------------------------------------------------------
    tpc_pkg::cfg_t     shadow_cfg = tpc_pkg::CFG_RESET;
    tpc_pkg::phase_t   ctl_phase = tpc_pkg::PH_NS_G;
    int                ctl_timer = 0;
    logic              ped_hold = 1'b0;
    logic              emerg_hold = 1'b0;
    logic [1:0]        emerg_dir_hold = 2'd0;
    logic              back_to_ns = 1'b0;
    tpc_pkg::preempt_t preempt = tpc_pkg::PT_NONE;
    logic              walk_on = 1'b0;
    logic              emerg_on = 1'b0;
    logic [1:0]        served_approach = 2'd0;

    // Lights predicted for accepted ticks whose result beat has not come yet.
    light_t     expected_lights[$];

    int         mismatches = 0;
    int unsigned cycle_count = 0;
    int         hold_left = 0;
    // When clear, neither side inserts gaps, so the block runs at full rate.
    bit         bursty = 1'b1;

    // A duration of zero still lasts one second.
    function automatic int one_or_more(input int v);
        return (v == 0) ? 1 : v;
    endfunction

    // Green length for the two approaches that are about to get green.
    function automatic int green_seconds(input int a, input int b);
        int t;
        t = int'(shadow_cfg.green_base) + (a + b) * int'(shadow_cfg.green_per_vehicle);
        if (t < int'(shadow_cfg.green_min)) begin
            t = int'(shadow_cfg.green_min);
        end
        if (t > int'(shadow_cfg.green_max)) begin
            t = int'(shadow_cfg.green_max);
        end
        return one_or_more(t);
    endfunction

    // Takes one second off the running phase; true once it has run out.
    function bit timer_expired();
        if (ctl_timer > 0) begin
            ctl_timer = ctl_timer - 1;
        end
        return ctl_timer == 0;
    endfunction

    // Enters a phase and loads its length. A green entered with a request
    // already waiting turns straight into that green's yellow.
    task enter_phase(input tpc_pkg::phase_t p, input tick_t t);
        case (p)
            tpc_pkg::PH_NS_G, tpc_pkg::PH_EW_G: begin
                walk_on = 1'b0;
                emerg_on = 1'b0;
                back_to_ns = 1'b0;
                if (emerg_hold || ped_hold) begin
                    preempt = emerg_hold ? tpc_pkg::PT_EMERG : tpc_pkg::PT_PED;
                    ctl_phase = (p == tpc_pkg::PH_NS_G) ? tpc_pkg::PH_NS_Y
                                                        : tpc_pkg::PH_EW_Y;
                    ctl_timer = one_or_more(int'(shadow_cfg.yellow_time));
                end else begin
                    ctl_phase = p;
                    if (p == tpc_pkg::PH_NS_G) begin
                        ctl_timer = green_seconds(int'(t.cn), int'(t.cs));
                    end else begin
                        ctl_timer = green_seconds(int'(t.ce), int'(t.cw));
                    end
                end
            end
            tpc_pkg::PH_NS_Y, tpc_pkg::PH_EW_Y, tpc_pkg::PH_EM_Y: begin
                ctl_phase = p;
                ctl_timer = one_or_more(int'(shadow_cfg.yellow_time));
            end
            tpc_pkg::PH_WALK: begin
                ctl_phase = p;
                ped_hold = 1'b0;
                preempt = tpc_pkg::PT_NONE;
                walk_on = 1'b1;
                emerg_on = 1'b0;
                ctl_timer = one_or_more(int'(shadow_cfg.walk_time));
            end
            tpc_pkg::PH_EM_G: begin
                ctl_phase = p;
                emerg_hold = 1'b0;
                served_approach = emerg_dir_hold;
                preempt = tpc_pkg::PT_NONE;
                emerg_on = 1'b1;
                walk_on = 1'b0;
                ctl_timer = one_or_more(int'(shadow_cfg.emergency_time));
            end
            default: begin
                ctl_phase = (p == tpc_pkg::PH_AR_2) ? tpc_pkg::PH_AR_2 : tpc_pkg::PH_AR_1;
                ctl_timer = one_or_more(int'(shadow_cfg.all_red_time));
            end
        endcase
    endtask

    // Advances the shadow by one tick and returns the lights it shows after it.
    task advance_lights(input tick_t t, output light_t r);
        tpc_pkg::phase_t p;
        tpc_pkg::lamp_t  lamps [4];
        if (ctl_phase == tpc_pkg::PH_HALT || t.stop) begin
            // Once halted, the controller stays halted whatever the ticks carry.
            ctl_phase = tpc_pkg::PH_HALT;
            ctl_timer = 0;
            ped_hold = 1'b0;
            emerg_hold = 1'b0;
            back_to_ns = 1'b0;
            preempt = tpc_pkg::PT_NONE;
            walk_on = 1'b0;
            emerg_on = 1'b0;
        end else begin
            p = ctl_phase;
            // Requests only latch on ticks spent in a green, walk or emergency.
            if (p inside {tpc_pkg::PH_NS_G, tpc_pkg::PH_EW_G, tpc_pkg::PH_WALK,
                          tpc_pkg::PH_EM_G}) begin
                if (t.ped && !ped_hold && !emerg_hold) begin
                    ped_hold = 1'b1;
                end
                if (t.emerg) begin
                    emerg_hold = 1'b1;
                    emerg_dir_hold = t.dir;
                end
            end
            case (p)
                tpc_pkg::PH_NS_G, tpc_pkg::PH_EW_G: begin
                    // A cleared timer in green means the first tick after reset.
                    if (ctl_timer == 0 && !ped_hold && !emerg_hold) begin
                        enter_phase(p, t);
                    end
                    if (ped_hold || emerg_hold) begin
                        preempt = emerg_hold ? tpc_pkg::PT_EMERG : tpc_pkg::PT_PED;
                        enter_phase((p == tpc_pkg::PH_NS_G) ? tpc_pkg::PH_NS_Y
                                                            : tpc_pkg::PH_EW_Y, t);
                    end else if (timer_expired()) begin
                        enter_phase((p == tpc_pkg::PH_NS_G) ? tpc_pkg::PH_NS_Y
                                                            : tpc_pkg::PH_EW_Y, t);
                    end
                end
                tpc_pkg::PH_NS_Y, tpc_pkg::PH_EW_Y: begin
                    if (timer_expired()) begin
                        enter_phase((p == tpc_pkg::PH_NS_Y) ? tpc_pkg::PH_AR_1
                                                            : tpc_pkg::PH_AR_2, t);
                    end
                end
                tpc_pkg::PH_AR_1, tpc_pkg::PH_AR_2: begin
                    if (timer_expired()) begin
                        if (preempt == tpc_pkg::PT_EMERG) begin
                            enter_phase(tpc_pkg::PH_EM_G, t);
                        end else if (preempt == tpc_pkg::PT_PED) begin
                            enter_phase(tpc_pkg::PH_WALK, t);
                        end else if (back_to_ns) begin
                            enter_phase(tpc_pkg::PH_NS_G, t);
                        end else begin
                            enter_phase((p == tpc_pkg::PH_AR_1) ? tpc_pkg::PH_EW_G
                                                                : tpc_pkg::PH_NS_G, t);
                        end
                    end
                end
                tpc_pkg::PH_WALK: begin
                    // An emergency cuts the walk short; all lamps are red already.
                    if (emerg_hold) begin
                        enter_phase(tpc_pkg::PH_EM_G, t);
                    end else if (timer_expired()) begin
                        back_to_ns = 1'b1;
                        enter_phase(tpc_pkg::PH_AR_1, t);
                    end
                end
                tpc_pkg::PH_EM_G: begin
                    if (timer_expired()) begin
                        enter_phase(tpc_pkg::PH_EM_Y, t);
                    end
                end
                tpc_pkg::PH_EM_Y: begin
                    if (timer_expired()) begin
                        back_to_ns = 1'b1;
                        enter_phase(tpc_pkg::PH_AR_1, t);
                    end
                end
                default: begin
                    enter_phase(tpc_pkg::PH_AR_1, t);
                end
            endcase
        end

        lamps = '{default: tpc_pkg::LAMP_RED};
        case (ctl_phase)
            tpc_pkg::PH_NS_G: begin
                lamps[0] = tpc_pkg::LAMP_GREEN;
                lamps[1] = tpc_pkg::LAMP_GREEN;
            end
            tpc_pkg::PH_NS_Y: begin
                lamps[0] = tpc_pkg::LAMP_YELLOW;
                lamps[1] = tpc_pkg::LAMP_YELLOW;
            end
            tpc_pkg::PH_EW_G: begin
                lamps[2] = tpc_pkg::LAMP_GREEN;
                lamps[3] = tpc_pkg::LAMP_GREEN;
            end
            tpc_pkg::PH_EW_Y: begin
                lamps[2] = tpc_pkg::LAMP_YELLOW;
                lamps[3] = tpc_pkg::LAMP_YELLOW;
            end
            tpc_pkg::PH_EM_G: begin
                lamps[served_approach] = tpc_pkg::LAMP_GREEN;
            end
            tpc_pkg::PH_EM_Y: begin
                lamps[served_approach] = tpc_pkg::LAMP_YELLOW;
            end
            default: begin
            end
        endcase
        r.north = lamps[0];
        r.south = lamps[1];
        r.east = lamps[2];
        r.west = lamps[3];
        r.phase = ctl_phase;
        r.secs = ctl_timer[7:0];
        r.walk = walk_on;
        r.emerg = emerg_on;
        r.ped = ped_hold;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Gap length shared by both sides: mostly none or short, now and then long.
    function automatic int pick_gap();
        int roll;
        if (!bursty) begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic tick_t make_tick(input bit ped, input bit emerg, input bit [1:0] dir,
                                        input bit stop);
        tick_t t;
        t.ped = ped;
        t.emerg = emerg;
        t.dir = dir;
        t.cn = 8'($urandom_range(0, 255));
        t.cs = 8'($urandom_range(0, 255));
        t.ce = 8'($urandom_range(0, 255));
        t.cw = 8'($urandom_range(0, 255));
        t.stop = stop;
        return t;
    endfunction

    // Random traffic: occasional requests, queue counts mostly small so the
    // per-vehicle term does not always sit at the clamp.
    function automatic tick_t random_tick();
        tick_t t;
        t = make_tick($urandom_range(0, 7) == 0, $urandom_range(0, 11) == 0,
                      2'($urandom_range(0, 3)), 1'b0);
        if ($urandom_range(0, 3) != 0) begin
            t.cn = 8'($urandom_range(0, 3));
            t.cs = 8'($urandom_range(0, 3));
            t.ce = 8'($urandom_range(0, 3));
            t.cw = 8'($urandom_range(0, 3));
        end
        return t;
    endfunction

    // Sends one tick beat and records the lights it should produce. Valid is
    // only lowered when a gap follows, so it never drops and rises in one step.
    task automatic send_tick(input tick_t t);
        int     gap;
        light_t predicted;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ped_request <= t.ped;
        s_emerg_request <= t.emerg;
        s_emerg_direction <= t.dir;
        s_count_north <= t.cn;
        s_count_south <= t.cs;
        s_count_east <= t.ce;
        s_count_west <= t.cw;
        s_stop_request <= t.stop;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        advance_lights(t, predicted);
        expected_lights.push_back(predicted);
    endtask

    // Lets every outstanding result beat drain, plus the block's latency.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_lights.size() != 0) begin
            @(posedge aclk);
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input tpc_pkg::cfg_addr_t idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            tpc_pkg::REG_GREEN_BASE:  shadow_cfg.green_base = value;
            tpc_pkg::REG_GREEN_PER_V: shadow_cfg.green_per_vehicle = value[3:0];
            tpc_pkg::REG_GREEN_MIN:   shadow_cfg.green_min = value;
            tpc_pkg::REG_GREEN_MAX:   shadow_cfg.green_max = value;
            tpc_pkg::REG_YELLOW:      shadow_cfg.yellow_time = value;
            tpc_pkg::REG_ALL_RED:     shadow_cfg.all_red_time = value;
            tpc_pkg::REG_WALK:        shadow_cfg.walk_time = value;
            default:                  shadow_cfg.emergency_time = value;
        endcase
        @(posedge aclk);
    endtask

    // Drains the block and loads a whole timing setting.
    task automatic load_timing(input tpc_pkg::cfg_t c);
        wait_idle();
        write_reg(tpc_pkg::REG_GREEN_BASE, c.green_base);
        write_reg(tpc_pkg::REG_GREEN_PER_V, {4'd0, c.green_per_vehicle});
        write_reg(tpc_pkg::REG_GREEN_MIN, c.green_min);
        write_reg(tpc_pkg::REG_GREEN_MAX, c.green_max);
        write_reg(tpc_pkg::REG_YELLOW, c.yellow_time);
        write_reg(tpc_pkg::REG_ALL_RED, c.all_red_time);
        write_reg(tpc_pkg::REG_WALK, c.walk_time);
        write_reg(tpc_pkg::REG_EMERGENCY, c.emergency_time);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches = mismatches + 1;
        if (mismatches <= MAX_PRINTED) begin
            $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_count, what, got,
                     want);
        end
    endtask

    // ------------------------------------------------------------------
    // Test tasks.
    // ------------------------------------------------------------------

    // Default timing: the first tick loads green from its own counts, here
    // at the top of the count range, then a tick with empty queues.
    task automatic test_power_up();
        tick_t t;
        t = make_tick(1'b0, 1'b0, 2'd0, 1'b0);
        t.cn = 8'hFF;
        t.cs = 8'hFF;
        t.ce = 8'hFF;
        t.cw = 8'hFF;
        send_tick(t);
        t.cn = 8'h00;
        t.cs = 8'h00;
        t.ce = 8'h00;
        t.cw = 8'h00;
        send_tick(t);
    endtask

    // Short phases so a whole preemption story fits in a few ticks:
    // pedestrian walk, emergency cutting the walk short, an emergency arriving
    // during another one and being served when the return to NS green is skipped, then
    // both requests on one tick, which lands in an all-red and so is not heard.
    task automatic test_preemption();
        tpc_pkg::cfg_t c;
        c = '{green_base: 8'd0, green_per_vehicle: 4'd1, green_min: 8'd1, green_max: 8'd3,
              yellow_time: 8'd1, all_red_time: 8'd1, walk_time: 8'd2, emergency_time: 8'd2};
        load_timing(c);
        send_tick(make_tick(1'b1, 1'b0, 2'd0, 1'b0));
        repeat (2) send_tick(make_tick(1'b0, 1'b0, 2'd0, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, 2'd3, 1'b0));
        send_tick(make_tick(1'b0, 1'b1, 2'd1, 1'b0));
        repeat (8) send_tick(make_tick(1'b0, 1'b0, 2'd0, 1'b0));
        send_tick(make_tick(1'b1, 1'b1, 2'd2, 1'b0));
    endtask

    // Every timing register at zero: each phase still lasts one second.
    task automatic test_zero_durations();
        load_timing('0);
        repeat (3) send_tick(make_tick(1'b0, 1'b0, 2'd0, 1'b0));
    endtask

    // Settings drawn per phase: short ones mostly, both extremes, a lower
    // clamp above the upper one, and two phases without any gaps.
    task automatic test_random_traffic();
        tpc_pkg::cfg_t c;
        int            n;
        for (int ph = 0; ph < 8; ph++) begin
            c.green_base = 8'($urandom_range(0, 6));
            c.green_per_vehicle = 4'($urandom_range(0, 15));
            c.green_min = 8'($urandom_range(1, 4));
            c.green_max = 8'($urandom_range(1, 12));
            c.yellow_time = 8'($urandom_range(1, 3));
            c.all_red_time = 8'($urandom_range(1, 3));
            c.walk_time = 8'($urandom_range(1, 3));
            c.emergency_time = 8'($urandom_range(1, 3));
            n = 100;
            case (ph)
                2: begin
                    c.green_base = 8'($urandom_range(0, 255));
                    c.green_min = 8'($urandom_range(1, 255));
                    c.green_max = 8'($urandom_range(1, 255));
                    c.yellow_time = 8'($urandom_range(1, 6));
                end
                5: begin
                    c = '{green_base: 8'd0, green_per_vehicle: 4'd0, green_min: 8'd1,
                          green_max: 8'd1, yellow_time: 8'd1, all_red_time: 8'd1,
                          walk_time: 8'd1, emergency_time: 8'd1};
                end
                6: begin
                    c.green_min = 8'($urandom_range(100, 255));
                    c.green_max = 8'($urandom_range(1, 8));
                end
                7: begin
                    c = '{green_base: 8'hFF, green_per_vehicle: 4'hF, green_min: 8'hFF,
                          green_max: 8'hFF, yellow_time: 8'hFF, all_red_time: 8'hFF,
                          walk_time: 8'hFF, emergency_time: 8'hFF};
                    n = 150;
                end
                default: begin
                end
            endcase
            load_timing(c);
            bursty = (ph != 1 && ph != 4);
            repeat (n) send_tick(random_tick());
        end
        bursty = 1'b1;
    endtask

    // Stop halts with every lamp red; later ticks, requests and all, change nothing.
    task automatic test_stop();
        send_tick(make_tick(1'b1, 1'b1, 2'd2, 1'b1));
        send_tick(make_tick(1'b1, 1'b1, 2'd1, 1'b0));
        send_tick(make_tick(1'b0, 1'b0, 2'd0, 1'b1));
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the field-by-field check of
    // every accepted result beat against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        light_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_lights.size() == 0) begin
                report_mismatch("result beat with nothing expected, phase", m_phase_code, -1);
            end else begin
                want = expected_lights.pop_front();
                if (m_lamp_north !== want.north) begin
                    report_mismatch("lamp_north", m_lamp_north, want.north);
                end
                if (m_lamp_south !== want.south) begin
                    report_mismatch("lamp_south", m_lamp_south, want.south);
                end
                if (m_lamp_east !== want.east) begin
                    report_mismatch("lamp_east", m_lamp_east, want.east);
                end
                if (m_lamp_west !== want.west) begin
                    report_mismatch("lamp_west", m_lamp_west, want.west);
                end
                if (m_phase_code !== want.phase) begin
                    report_mismatch("phase_code", m_phase_code, want.phase);
                end
                if (m_seconds_left !== want.secs) begin
                    report_mismatch("seconds_left", m_seconds_left, want.secs);
                end
                if (m_walk_active !== want.walk) begin
                    report_mismatch("walk_active", m_walk_active, want.walk);
                end
                if (m_emergency_active !== want.emerg) begin
                    report_mismatch("emergency_active", m_emergency_active, want.emerg);
                end
                if (m_ped_pending !== want.ped) begin
                    report_mismatch("ped_pending", m_ped_pending, want.ped);
                end
            end
        end

        // Stalls start at random and run for a drawn number of cycles.
        if (!bursty) begin
            hold_left = 0;
            m_ready <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            hold_left = pick_gap();
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_power_up();
        test_preemption();
        test_zero_durations();
        test_random_traffic();
        test_stop();

        wait_idle();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
